>>> hdl/grsi_pkg.sv
`default_nettype none

package grsi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TRIG_FRAC   = 16;
    localparam int HEIGHT_W    = 12;
    localparam int TRIG_W      = 17;
    localparam int QCAP        = 62;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    // Datapath widths for the default fraction width.
    localparam int OFF_W_DEF  = TRIG_W + HEIGHT_W
                              + ((FRAC_BITS > TRIG_FRAC) ? FRAC_BITS - TRIG_FRAC : 0);
    localparam int H_W_DEF    = ((COORD_WIDTH > OFF_W_DEF) ? COORD_WIDTH : OFF_W_DEF) + 2;
    localparam int DEN_W      = COORD_WIDTH + TRIG_W + 1;
    localparam int PROD_W_DEF = H_W_DEF + TRIG_W + 1 + COORD_WIDTH;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd320;
    localparam logic [TRIG_W-1:0]   COS_RST    = 17'd46341;
    localparam logic [TRIG_W-1:0]   SIN_RST    = 17'd46341;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_COS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_SIN      = 2'd2;

    localparam logic CMD_POS = 1'b0;
    localparam logic CMD_DIR = 1'b1;

    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_WIDTH-1:0] comp_x;
        logic signed [COORD_WIDTH-1:0] comp_y;
        logic signed [COORD_WIDTH-1:0] comp_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] gaze_x;
        logic signed [COORD_WIDTH-1:0] gaze_y;
        logic signed [COORD_WIDTH-1:0] gaze_z;
        logic                          parallel;
        logic                          saturated;
    } t_out_item;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_cmd;

    typedef struct packed {
        logic done;
        logic big;
    } t_mdu_sts;

endpackage

`default_nettype wire

>>> hdl/grsi_mdu.sv
`default_nettype none

// Shared multiply / divide unit. Multiply is shift-and-add, one multiplier
// bit per cycle, and ends as soon as the remaining multiplier bits are zero.
// Divide is restoring long division of a MUL_W-bit dividend by a DIV_W-bit
// divisor with the quotient capped at 2**QCAP: the cap is checked first, then
// one quotient bit is produced per cycle.
module grsi_mdu #(
    parameter int MUL_W = grsi_pkg::PROD_W_DEF,
    parameter int DIV_W = grsi_pkg::DEN_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  grsi_pkg::t_mdu_cmd      i_cmd,
    input  wire logic [MUL_W-1:0]   i_a,
    input  wire logic [DIV_W-1:0]   i_b,
    output grsi_pkg::t_mdu_sts      o_sts,
    output logic      [MUL_W-1:0]   o_res
);

    localparam int QCAP  = grsi_pkg::QCAP;
    localparam int HI_W  = MUL_W - QCAP;
    localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;
    localparam int CNT_W = $clog2(QCAP + 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } t_state;

    t_state             r_state;
    logic [MUL_W-1:0]   r_acc;
    logic [MUL_W-1:0]   r_a;
    logic [DIV_W-1:0]   r_b;
    logic [DIV_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic               r_big;

    logic [HI_W-1:0]    w_hi;
    logic               w_big;
    logic [DIV_W:0]     w_trial;
    logic [DIV_W:0]     w_diff;
    logic               w_fit;
    logic [MUL_W-1:0]   w_sum;

    // The quotient reaches the cap exactly when the dividend bits above the
    // cap already hold at least one divisor.
    assign w_hi    = i_a[MUL_W-1:QCAP];
    assign w_big   = CMP_W'(w_hi) >= CMP_W'(i_b);

    assign w_trial = {r_rem, r_a[QCAP-1]};
    assign w_diff  = w_trial - {1'b0, r_b};
    assign w_fit   = ~w_diff[DIV_W];
    assign w_sum   = r_acc + r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_big   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_cmd.start) begin
                        r_acc <= '0;
                        r_b   <= i_b;
                        r_big <= 1'b0;
                        if (i_cmd.op == grsi_pkg::MDU_MUL) begin
                            r_a     <= i_a;
                            r_state <= M_MUL;
                        end else if (w_big) begin
                            r_big  <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            // The upper part is below the divisor, so it fits.
                            r_rem   <= DIV_W'(w_hi);
                            r_a     <= i_a;
                            r_cnt   <= CNT_W'(QCAP);
                            r_state <= M_DIV;
                        end
                    end
                end
                M_MUL: begin
                    if (r_b == '0) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        if (r_b[0]) begin
                            r_acc <= w_sum;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                end
                M_DIV: begin
                    r_acc <= {r_acc[MUL_W-2:0], w_fit};
                    r_rem <= w_fit ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                    r_a   <= r_a << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.big  = r_big;
    assign o_res      = r_acc;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_state == M_IDLE)
        else $error("mdu started while busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == M_DIV |-> r_rem < r_b)
        else $error("mdu partial remainder not below divisor");

    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == M_IDLE)
        else $error("mdu done flag outside idle");

endmodule

`default_nettype wire

>>> hdl/gaze_ray_screen_intersection_top.sv
`default_nettype none

// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    i_in_data  (grsi_pkg::t_in_item)
// out      out  o_out_valid / i_out_stall  o_out_data (grsi_pkg::t_out_item)
// cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A position request is stored as the new head and gives no result.
// A direction request runs twelve operations on the one shared multiply/divide
// unit: six short multiplies, then three multiplies and three capped divides
// of 62 steps each; a ray parallel to the screen ends after the first six.
// o_in_stall is high from the accept of a direction request until its result
// is in the output register, which holds one result while the next request
// is taken. Synchronous reset restores the register defaults and a zero head.
module gaze_ray_screen_intersection_top #(
    parameter int FRAC_BITS = grsi_pkg::FRAC_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  grsi_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output grsi_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [grsi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [grsi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW     = grsi_pkg::COORD_WIDTH;
    localparam int TW     = grsi_pkg::TRIG_W;
    localparam int HTW    = grsi_pkg::HEIGHT_W;
    localparam int QCAP   = grsi_pkg::QCAP;
    localparam int TF     = grsi_pkg::TRIG_FRAC;
    localparam int SHL    = (FRAC_BITS >= TF) ? FRAC_BITS - TF : 0;
    localparam int SHR    = (FRAC_BITS < TF) ? TF - FRAC_BITS : 0;
    localparam int PSM_W  = TW + HTW;
    localparam int OFF_W  = PSM_W + SHL;
    localparam int H_W    = ((CW > OFF_W) ? CW : OFF_W) + 2;
    localparam int NUM_W  = H_W + TW + 1;
    localparam int DEN_W  = CW + TW + 1;
    localparam int MUL_W  = NUM_W + CW;
    localparam int SUM_W  = QCAP + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_FIN
    } t_state;

    // Operation order: two screen offsets, numerator, denominator, then a
    // multiply and a divide for each point component.
    typedef enum logic [2:0] {
        ST_SH,
        ST_CH,
        ST_CN,
        ST_SN,
        ST_CD,
        ST_SD,
        ST_MP,
        ST_DV
    } t_step;

    function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] x);
        mag_c = x[CW-1] ? CW'(-x) : CW'(x);
    endfunction

    function automatic logic [H_W-1:0] mag_h(input logic signed [H_W-1:0] x);
        mag_h = x[H_W-1] ? H_W'(-x) : H_W'(x);
    endfunction

    t_state                     r_state;
    t_step                      r_step;
    logic [1:0]                 r_idx;
    logic [HTW-1:0]             r_height;
    logic [TW-1:0]              r_cos;
    logic [TW-1:0]              r_sin;
    logic signed [CW-1:0]       r_px;
    logic signed [CW-1:0]       r_py;
    logic signed [CW-1:0]       r_pz;
    logic signed [H_W-1:0]      r_h    [3];
    logic [CW-1:0]              r_vmag [3];
    logic                       r_vneg [3];
    logic signed [CW-1:0]       r_g    [3];
    logic signed [NUM_W:0]      r_num;
    logic signed [DEN_W:0]      r_den;
    logic                       r_sat;
    logic                       r_par;
    logic                       r_out_valid;
    grsi_pkg::t_out_item        r_out;

    grsi_pkg::t_mdu_cmd         w_cmd;
    grsi_pkg::t_mdu_sts         w_sts;
    logic [MUL_W-1:0]           w_a;
    logic [DEN_W-1:0]           w_b;
    logic [MUL_W-1:0]           w_mdu_res;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic [OFF_W-1:0]           w_off;
    logic signed [NUM_W:0]      w_pn;
    logic signed [DEN_W:0]      w_pd;
    logic signed [DEN_W:0]      w_den_next;
    logic [NUM_W:0]             w_num_neg;
    logic [DEN_W:0]             w_den_neg;
    logic [NUM_W-1:0]           w_num_mag;
    logic [DEN_W-1:0]           w_den_mag;
    logic [SUM_W-1:0]           w_term;
    logic                       w_tneg;
    logic signed [SUM_W-1:0]    w_hsel;
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_ovf_pos;
    logic                       w_ovf_neg;
    logic signed [CW-1:0]       w_clamp;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_off      = (OFF_W'(w_mdu_res[PSM_W-1:0]) << SHL) >> SHR;
    assign w_pn       = signed'({1'b0, w_mdu_res[NUM_W-1:0]});
    assign w_pd       = signed'({1'b0, w_mdu_res[DEN_W-1:0]});
    assign w_den_next = r_vneg[2] ? r_den + w_pd : r_den - w_pd;

    assign w_num_neg  = -r_num;
    assign w_den_neg  = -r_den;
    assign w_num_mag  = r_num[NUM_W] ? w_num_neg[NUM_W-1:0] : r_num[NUM_W-1:0];
    assign w_den_mag  = r_den[DEN_W] ? w_den_neg[DEN_W-1:0] : r_den[DEN_W-1:0];

    // t = -num/den, so a term is negative when num, v and den carry an even
    // number of minus signs.
    assign w_term     = w_sts.big ? (SUM_W'(1) << QCAP) : SUM_W'(w_mdu_res[QCAP-1:0]);
    assign w_tneg     = ~(r_num[NUM_W] ^ r_vneg[r_idx] ^ r_den[DEN_W]);
    assign w_hsel     = SUM_W'(r_h[r_idx]);
    assign w_sum      = w_tneg ? w_hsel - signed'(w_term) : w_hsel + signed'(w_term);
    assign w_ovf_pos  = !w_sum[SUM_W-1] && (|w_sum[SUM_W-2:CW-1]);
    assign w_ovf_neg  = w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:CW-1]);

    always_comb begin
        if (w_ovf_pos) begin
            w_clamp = {1'b0, {(CW-1){1'b1}}};
        end else if (w_ovf_neg) begin
            w_clamp = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_clamp = w_sum[CW-1:0];
        end
    end

    assign w_cmd.start = (r_state == S_RUN);
    assign w_cmd.op    = (r_step == ST_DV) ? grsi_pkg::MDU_DIV : grsi_pkg::MDU_MUL;

    always_comb begin
        case (r_step)
            ST_SH: begin
                w_a = MUL_W'(r_height);
                w_b = DEN_W'(r_sin);
            end
            ST_CH: begin
                w_a = MUL_W'(r_height);
                w_b = DEN_W'(r_cos);
            end
            ST_CN: begin
                w_a = MUL_W'(mag_h(r_h[1]));
                w_b = DEN_W'(r_cos);
            end
            ST_SN: begin
                w_a = MUL_W'(mag_h(r_h[2]));
                w_b = DEN_W'(r_sin);
            end
            ST_CD: begin
                w_a = MUL_W'(r_vmag[1]);
                w_b = DEN_W'(r_cos);
            end
            ST_SD: begin
                w_a = MUL_W'(r_vmag[2]);
                w_b = DEN_W'(r_sin);
            end
            ST_MP: begin
                w_a = MUL_W'(w_num_mag);
                w_b = DEN_W'(r_vmag[r_idx]);
            end
            ST_DV: begin
                // The product from the step before still sits in the unit.
                w_a = w_mdu_res;
                w_b = w_den_mag;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    grsi_mdu #(
        .MUL_W (MUL_W),
        .DIV_W (DEN_W)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_sts   (w_sts),
        .o_res   (w_mdu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_height    <= grsi_pkg::HEIGHT_RST;
            r_cos       <= grsi_pkg::COS_RST;
            r_sin       <= grsi_pkg::SIN_RST;
            r_px        <= '0;
            r_py        <= '0;
            r_pz        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    grsi_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data[HTW-1:0];
                    grsi_pkg::REG_TILT_COS:      r_cos    <= i_cfg_data[TW-1:0];
                    grsi_pkg::REG_TILT_SIN:      r_sin    <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.cmd == grsi_pkg::CMD_POS) begin
                            r_px <= i_in_data.comp_x;
                            r_py <= i_in_data.comp_y;
                            r_pz <= i_in_data.comp_z;
                        end else begin
                            // World frame: (-x, -z, -y) for both the head and the ray.
                            r_h[0]    <= -(H_W'(r_px));
                            r_h[1]    <= -(H_W'(r_pz));
                            r_h[2]    <= -(H_W'(r_py));
                            r_vmag[0] <= mag_c(i_in_data.comp_x);
                            r_vmag[1] <= mag_c(i_in_data.comp_z);
                            r_vmag[2] <= mag_c(i_in_data.comp_y);
                            r_vneg[0] <= !i_in_data.comp_x[CW-1] && (i_in_data.comp_x != '0);
                            r_vneg[1] <= !i_in_data.comp_z[CW-1] && (i_in_data.comp_z != '0);
                            r_vneg[2] <= !i_in_data.comp_y[CW-1] && (i_in_data.comp_y != '0);
                            r_g[0]    <= '0;
                            r_g[1]    <= '0;
                            r_g[2]    <= '0;
                            r_sat     <= 1'b0;
                            r_par     <= 1'b0;
                            r_idx     <= '0;
                            r_step    <= ST_SH;
                            r_state   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_sts.done) begin
                        r_state <= S_RUN;
                        case (r_step)
                            ST_SH: begin
                                r_h[1] <= r_h[1] + signed'(H_W'(w_off));
                                r_step <= ST_CH;
                            end
                            ST_CH: begin
                                r_h[2] <= r_h[2] + signed'(H_W'(w_off));
                                r_step <= ST_CN;
                            end
                            ST_CN: begin
                                r_num  <= r_h[1][H_W-1] ? -w_pn : w_pn;
                                r_step <= ST_SN;
                            end
                            ST_SN: begin
                                r_num  <= r_h[2][H_W-1] ? r_num + w_pn : r_num - w_pn;
                                r_step <= ST_CD;
                            end
                            ST_CD: begin
                                r_den  <= r_vneg[1] ? -w_pd : w_pd;
                                r_step <= ST_SD;
                            end
                            ST_SD: begin
                                r_den  <= w_den_next;
                                r_step <= ST_MP;
                                // A ray parallel to the screen gives a zero point.
                                if (w_den_next == '0) begin
                                    r_par   <= 1'b1;
                                    r_state <= S_FIN;
                                end
                            end
                            ST_MP: begin
                                r_step <= ST_DV;
                            end
                            ST_DV: begin
                                r_g[r_idx] <= w_clamp;
                                r_sat      <= r_sat | w_ovf_pos | w_ovf_neg;
                                r_step     <= ST_MP;
                                if (r_idx == 2'd2) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_idx <= r_idx + 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out.gaze_x    <= r_g[0];
                        r_out.gaze_y    <= r_g[1];
                        r_out.gaze_z    <= r_g[2];
                        r_out.parallel  <= r_par;
                        r_out.saturated <= r_sat;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> r_state == S_WAIT)
        else $error("unit result arrived outside the wait state");

    a_dir_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.cmd == grsi_pkg::CMD_DIR) |=> r_state == S_RUN)
        else $error("direction request did not start the sequence");

    a_no_zero_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == ST_DV) |-> r_den != '0)
        else $error("divide issued with a zero denominator");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.parallel) |-> (r_out.gaze_x == '0 && r_out.gaze_y == '0
            && r_out.gaze_z == '0 && !r_out.saturated))
        else $error("parallel result with a nonzero point or saturation");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import grsi_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int     SETTLE_CYC  = 500;
    localparam int     HOLD_CYC    = 3000;
    localparam int     PHASE_REQS  = 210;
    localparam int     NUM_PHASES  = 8;
    localparam int     NUM_ROWS    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH-1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic [127:0] TERM_CAP = 128'd1 << QCAP;

    localparam t_out_item PARALLEL_RES = {{(3*COORD_WIDTH){1'b0}}, 1'b1, 1'b0};
    localparam t_out_item NO_RES       = '0;

    typedef struct packed {
        t_in_item  rq;
        logic      typed;
        t_out_item res;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Predictor copy of the head position and the screen registers.
    logic signed [COORD_WIDTH-1:0] head_x, head_y, head_z;
    longint height_q, cos_q, sin_q;

    t_out_item pending_gaze[$];
    t_dir_row  directed_tbl [NUM_ROWS];

    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    int     hold_left     = 0;
    longint cycle_cnt     = 0;
    int     n_fail = 0, n_checked = 0, n_parallel = 0, n_clamped = 0;
    int     n_pos = 0, n_dir = 0, n_cfg = 0;

    gaze_ray_screen_intersection_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Intersection of the head ray with the tilted screen, in world coordinates.
    function automatic t_out_item project_gaze(input t_in_item rq);
        t_out_item r;
        longint h [3];
        longint v [3];
        longint num, den, term, sum;
        logic [127:0] num_mag, den_mag, v_mag, q;
        logic [COORD_WIDTH-1:0] g [3];
        logic neg;
        r = '0;
        h[0] = -longint'(head_x);
        h[1] = -longint'(head_z) + sin_q * height_q;
        h[2] = -longint'(head_y) + cos_q * height_q;
        v[0] = -longint'(rq.comp_x);
        v[1] = -longint'(rq.comp_z);
        v[2] = -longint'(rq.comp_y);
        num = cos_q * h[1] - sin_q * h[2];
        den = cos_q * v[1] - sin_q * v[2];
        if (den == 0) begin
            r.parallel = 1'b1;
            return r;
        end
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        for (int i = 0; i < 3; i++) begin
            v_mag = (v[i] < 0) ? -v[i] : v[i];
            q = (num_mag * v_mag) / den_mag;
            if (q > TERM_CAP) q = TERM_CAP;
            // t = -num/den, so the term is negative when num*v/den is positive.
            neg = !((num < 0) ^ (v[i] < 0) ^ (den < 0));
            term = longint'(q[63:0]);
            if (neg) term = -term;
            sum = h[i] + term;
            if (sum > COORD_MAX) begin
                sum = COORD_MAX;
                r.saturated = 1'b1;
            end else if (sum < COORD_MIN) begin
                sum = COORD_MIN;
                r.saturated = 1'b1;
            end
            g[i] = sum[COORD_WIDTH-1:0];
        end
        r.gaze_x = g[0];
        r.gaze_y = g[1];
        r.gaze_z = g[2];
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        logic [COORD_WIDTH-1:0] c;
        case ($urandom_range(9))
            0, 1, 2, 3: c = $urandom();
            4, 5, 6:    c = $urandom_range(32'h07D0_0000) - 32'h03E8_0000;
            7:          c = $urandom_range(16) - 8;
            default: begin
                case ($urandom_range(3))
                    0:       c = MAXC;
                    1:       c = MINC;
                    2:       c = '0;
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic t_in_item rand_request();
        t_in_item rq;
        rq.cmd = ($urandom_range(99) < 35) ? CMD_POS : CMD_DIR;
        rq.comp_x = rand_coord();
        rq.comp_y = rand_coord();
        rq.comp_z = rand_coord();
        // Steer some directions close to the plane so the divide sees tiny divisors.
        if (rq.cmd == CMD_DIR && $urandom_range(7) == 0)
            rq.comp_z = rq.comp_y + $urandom_range(2) - 1;
        return rq;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCREEN_HEIGHT: height_q = longint'(data[HEIGHT_W-1:0]);
            REG_TILT_COS:      cos_q = longint'(data[TRIG_W-1:0]);
            REG_TILT_SIN:      sin_q = longint'(data[TRIG_W-1:0]);
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_request(input t_dir_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= row.rq;
        do @(posedge i_clk); while (o_in_stall);
        if (row.rq.cmd == CMD_POS) begin
            head_x = row.rq.comp_x;
            head_y = row.rq.comp_y;
            head_z = row.rq.comp_z;
            n_pos++;
        end else begin
            pending_gaze.push_back(row.typed ? row.res : project_gaze(row.rq));
            n_dir++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_for_quiet();
        while (pending_gaze.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic note_failure(input string what, input t_out_item want,
                                input t_out_item got);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t %s: want x=%h y=%h z=%h par=%b sat=%b, got x=%h y=%h z=%h par=%b sat=%b",
                     $time, what, want.gaze_x, want.gaze_y, want.gaze_z, want.parallel,
                     want.saturated, got.gaze_x, got.gaze_y, got.gaze_z, got.parallel,
                     got.saturated);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (o_out_data.parallel === 1'b1) n_parallel++;
            if (o_out_data.saturated === 1'b1) n_clamped++;
            if (pending_gaze.size() == 0) begin
                note_failure("unexpected result", NO_RES, o_out_data);
            end else begin
                want = pending_gaze.pop_front();
                if (o_out_data.gaze_x !== want.gaze_x || o_out_data.gaze_y !== want.gaze_y ||
                    o_out_data.gaze_z !== want.gaze_z ||
                    o_out_data.parallel !== want.parallel ||
                    o_out_data.saturated !== want.saturated)
                    note_failure("result mismatch", want, o_out_data);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, pending_gaze.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_dir_row row;
        int idle_send [4];
        int idle_stall [4];
        idle_send  = '{0, 87, 0, 11};
        idle_stall = '{0, 0, 87, 11};
        head_x   = '0;
        head_y   = '0;
        head_z   = '0;
        height_q = longint'(HEIGHT_RST);
        cos_q    = longint'(COS_RST);
        sin_q    = longint'(SIN_RST);

        // Directions before any position use the zero head; with the reset tilt
        // (cos equal to sin) any direction with y equal to z is parallel.
        directed_tbl[0]  = {CMD_DIR, 32'h0, 32'h0, 32'h0, 1'b1, PARALLEL_RES};
        directed_tbl[1]  = {CMD_DIR, 32'h0001_0000, 32'h0003_0000, 32'hFFFE_0000, 1'b0, NO_RES};
        directed_tbl[2]  = {CMD_DIR, MAXC, 32'h7, 32'h7, 1'b1, PARALLEL_RES};
        directed_tbl[3]  = {CMD_DIR, MINC, MINC, MINC, 1'b1, PARALLEL_RES};
        directed_tbl[4]  = {CMD_DIR, 32'h1, 32'h0, 32'h0, 1'b1, PARALLEL_RES};
        directed_tbl[5]  = {CMD_POS, 32'h0, MAXC, MINC, 1'b0, NO_RES};
        // Divisor of one tilt step with a huge numerator: the term is capped.
        directed_tbl[6]  = {CMD_DIR, MINC, 32'h0, 32'h1, 1'b0, NO_RES};
        directed_tbl[7]  = {CMD_DIR, MAXC, MAXC, MINC, 1'b0, NO_RES};
        directed_tbl[8]  = {CMD_POS, MINC, MINC, MINC, 1'b0, NO_RES};
        directed_tbl[9]  = {CMD_DIR, MAXC, MINC, MAXC, 1'b0, NO_RES};
        directed_tbl[10] = {CMD_POS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RES};
        directed_tbl[11] = {CMD_DIR, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_RES};
        directed_tbl[12] = {CMD_POS, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0, NO_RES};
        directed_tbl[13] = {CMD_DIR, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 1'b0, NO_RES};
        directed_tbl[14] = {CMD_POS, 32'h000A_0000, 32'h0014_0000, 32'h01F4_0000, 1'b0, NO_RES};
        directed_tbl[15] = {CMD_DIR, 32'h0, 32'h0001_0000, 32'h0003_0000, 1'b0, NO_RES};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_request(directed_tbl[r]);
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_quiet();
            case (ph)
                0: begin
                    cfg_write(REG_SCREEN_HEIGHT, 17'd4095);
                    cfg_write(REG_TILT_COS, 17'd65536);
                    cfg_write(REG_TILT_SIN, 17'd0);
                end
                1: begin
                    cfg_write(REG_SCREEN_HEIGHT, 17'd0);
                    cfg_write(REG_TILT_COS, 17'd0);
                    cfg_write(REG_TILT_SIN, 17'd65536);
                end
                2: begin
                    cfg_write(REG_SCREEN_HEIGHT, 17'd1024);
                    cfg_write(REG_TILT_COS, 17'd131071);
                    cfg_write(REG_TILT_SIN, 17'd131071);
                end
                3: begin
                    // Upper data bits must be dropped by the 12-bit height register.
                    cfg_write(REG_SCREEN_HEIGHT, 17'h1FFFF);
                    cfg_write(REG_TILT_COS, 17'd0);
                    cfg_write(REG_TILT_SIN, 17'd0);
                    cfg_write(REG_UNUSED, 17'h1FFFF);
                end
                4: begin
                    cfg_write(REG_SCREEN_HEIGHT, HEIGHT_RST);
                    cfg_write(REG_TILT_COS, COS_RST);
                    cfg_write(REG_TILT_SIN, SIN_RST);
                end
                default: begin
                    cfg_write(REG_SCREEN_HEIGHT, $urandom_range(17'h1FFFF));
                    cfg_write(REG_TILT_COS, $urandom_range(131071));
                    cfg_write(REG_TILT_SIN, $urandom_range(131071));
                end
            endcase
            send_idle_pct = idle_send[ph % 4];
            stall_pct     = idle_stall[ph % 4];
            if (ph == 4) begin
                // Long receiver hold-off while requests keep coming, so the block backs up.
                @(posedge i_clk);
                hold_left = HOLD_CYC;
                @(negedge i_clk);
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                row.rq    = rand_request();
                row.typed = 1'b0;
                row.res   = NO_RES;
                send_request(row);
            end
            i_in_valid <= 1'b0;
        end

        while (pending_gaze.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("sent %0d position and %0d direction requests over %0d register writes",
                 n_pos, n_dir, n_cfg);
        $display("checked %0d results (%0d parallel, %0d clamped), %0d failures",
                 n_checked, n_parallel, n_clamped, n_fail);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/grsi_pkg.sv
hdl/grsi_mdu.sv
hdl/gaze_ray_screen_intersection_top.sv
sim/tb.sv
